[hw/rtl/min_heap_insert_delete_key_defines.svh]
// Assertion helpers for the heap block. Both sample on clk and stay quiet in reset.
`ifndef MIN_HEAP_INSERT_DELETE_KEY_DEFINES_SVH
`define MIN_HEAP_INSERT_DELETE_KEY_DEFINES_SVH

`ifndef SYNTHESIS
`define MHIK_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap check failed");
`define MHIK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap check failed");
`else
`define MHIK_ASSERT_SAME(lbl, ante, cons)
`define MHIK_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/mhik_pkg.sv]
`default_nettype none

package mhik_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int COUNT_OUT_W  = 7;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_DELETE = 1'b1
    } req_t;

endpackage

`default_nettype wire

[hw/rtl/mhik_ram.sv]
`default_nettype none

// Simple dual-port store: one write, one registered read per cycle.
module mhik_ram
    import mhik_pkg::*;
#(
    parameter int DEPTH  = CAPACITY_DEF,
    parameter int ADDR_W = $clog2(CAPACITY_DEF)
)
(
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [ADDR_W-1:0]        wr_addr,
    input  wire logic signed [DATA_W-1:0] wr_data,
    input  wire logic                     rd_en,
    input  wire logic [ADDR_W-1:0]        rd_addr,
    output logic signed [DATA_W-1:0]      rd_data
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/min_heap_insert_delete_key.sv]
`default_nettype none

// Binary min-heap of signed 32-bit values, held in a one-read one-write store.
// Command channel: drive req_type and value with start; the request transfers
// on a rising edge where start is high and busy is low. req_type 0 inserts
// value, 1 removes the first stored entry equal to value.
// Result channel: done pulses for one cycle with status (ok, empty, not found,
// full), min_value (root, zero when empty) and entry_count. The receiver
// cannot stall; each result is valid only in its done cycle.
// Steps from the transfer to done:
//   insert: the new value rises from the end slot level by level, each larger
//           parent moving down into the hole, and is written where it stops
//   delete: entries are searched in order from index 0; unless the match was
//           the last entry, the last entry is fetched into the hole and
//           either rises or sinks level by level until it settles
//   full, empty or key missing: no sift; a missing key ends after the search.
// The store has a single read port: one entry is read per cycle, and a
// sift-down level reads the left child, then the right child if there is one.
// One request at a time; busy stays high until the result is posted.
// Reset empties the heap at once; store contents are not cleared.
module min_heap_insert_delete_key
    import mhik_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          req_type,
    input  wire logic signed [DATA_W-1:0]      value,
    output logic                               done,
    output logic [1:0]                         status,
    output logic signed [DATA_W-1:0]           min_value,
    output logic [COUNT_OUT_W-1:0]             entry_count
);

`include "min_heap_insert_delete_key_defines.svh"

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CHILD_W = ADDR_W + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_LAST_WT,
        S_UP_RD,
        S_UP_CMP,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_FIN
    } state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         scan_reg;
    logic [ADDR_W-1:0]        cmp_idx_reg;
    logic                     cmp_vld_reg;
    logic [ADDR_W-1:0]        pos_reg;
    logic signed [DATA_W-1:0] cur_val_reg;
    logic signed [DATA_W-1:0] l_val_reg;
    logic                     r_ok_reg;
    logic                     try_dn_reg;
    logic signed [DATA_W-1:0] root_reg;
    status_t                  status_reg;

    logic                     done_reg;
    status_t                  status_out_reg;
    logic signed [DATA_W-1:0] min_out_reg;
    logic [COUNT_OUT_W-1:0]   cnt_out_reg;

    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    logic [CNT_W-1:0]         cnt_m1;
    logic                     accept;
    logic                     match;
    logic                     last_cmp;
    logic                     hit_last;
    logic                     scan_more;
    logic [ADDR_W-1:0]        parent;
    logic [CHILD_W-1:0]       lc;
    logic [CHILD_W-1:0]       rc;
    logic                     l_in;
    logic                     r_in;
    logic                     up_less;
    logic                     l_less;
    logic signed [DATA_W-1:0] l_best;
    logic                     r_less;
    logic                     dn_move;
    logic signed [DATA_W-1:0] dn_val;
    logic [ADDR_W-1:0]        dn_idx;

    mhik_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign cnt_m1    = count_reg - CNT_W'(1);
    assign match     = cmp_vld_reg && (rd_data == cur_val_reg);
    assign last_cmp  = cmp_vld_reg && (CNT_W'(cmp_idx_reg) == cnt_m1);
    assign hit_last  = (CNT_W'(cmp_idx_reg) == cnt_m1);
    assign scan_more = (scan_reg < count_reg);

    assign parent = (pos_reg - ADDR_W'(1)) >> 1;
    assign lc     = CHILD_W'({pos_reg, 1'b1});
    assign rc     = lc + CHILD_W'(1);
    assign l_in   = (lc < CHILD_W'(count_reg));
    assign r_in   = (rc < CHILD_W'(count_reg));

    assign up_less = (cur_val_reg < rd_data);
    assign l_less  = (l_val_reg < cur_val_reg);
    assign l_best  = l_less ? l_val_reg : cur_val_reg;
    assign r_less  = r_ok_reg && (rd_data < l_best);
    assign dn_move = l_less || r_less;
    assign dn_val  = r_less ? rd_data : l_val_reg;
    assign dn_idx  = r_less ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];

    // Store port control. The walk never reads an entry it wrote in the
    // same cycle (a parent or child of the hole, never the hole), so the
    // store needs no bypass.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = cur_val_reg;
        unique case (state_reg)
            S_SRCH:
            begin
                if (match)
                begin
                    if (!hit_last)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = cnt_m1[ADDR_W-1:0];
                    end
                end
                else if (!last_cmp && scan_more)
                begin
                    rd_en   = 1'b1;
                    rd_addr = scan_reg[ADDR_W-1:0];
                end
            end
            S_UP_RD:
            begin
                if (pos_reg != '0)
                begin
                    rd_en   = 1'b1;
                    rd_addr = parent;
                end
                else if (!try_dn_reg)
                begin
                    wr_en = 1'b1;
                end
            end
            S_UP_CMP:
            begin
                if (up_less)
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                end
                else if (!try_dn_reg)
                begin
                    wr_en = 1'b1;
                end
            end
            S_DN_L:
            begin
                if (l_in)
                begin
                    rd_en   = 1'b1;
                    rd_addr = lc[ADDR_W-1:0];
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
            S_DN_R:
            begin
                if (r_in)
                begin
                    rd_en   = 1'b1;
                    rd_addr = rc[ADDR_W-1:0];
                end
            end
            S_DN_CMP:
            begin
                wr_en   = 1'b1;
                wr_data = dn_move ? dn_val : cur_val_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            try_dn_reg     <= 1'b0;
            r_ok_reg       <= 1'b0;
            status_reg     <= ST_OK;
            status_out_reg <= ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            if (wr_en && (wr_addr == '0))
            begin
                root_reg <= wr_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg  <= ST_OK;
                        cur_val_reg <= value;
                        if (req_type == REQ_INSERT)
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_reg <= ST_FULL;
                                state_reg  <= S_FIN;
                            end
                            else
                            begin
                                pos_reg    <= count_reg[ADDR_W-1:0];
                                count_reg  <= count_reg + CNT_W'(1);
                                try_dn_reg <= 1'b0;
                                state_reg  <= S_UP_RD;
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            status_reg <= ST_EMPTY;
                            state_reg  <= S_FIN;
                        end
                        else
                        begin
                            scan_reg    <= '0;
                            cmp_vld_reg <= 1'b0;
                            state_reg   <= S_SRCH;
                        end
                    end
                end
                S_SRCH:
                begin
                    if (match)
                    begin
                        count_reg <= cnt_m1;
                        pos_reg   <= cmp_idx_reg;
                        state_reg <= hit_last ? S_FIN : S_LAST_WT;
                    end
                    else if (last_cmp)
                    begin
                        status_reg <= ST_NOT_FOUND;
                        state_reg  <= S_FIN;
                    end
                    else
                    begin
                        cmp_vld_reg <= scan_more;
                        cmp_idx_reg <= scan_reg[ADDR_W-1:0];
                        if (scan_more)
                        begin
                            scan_reg <= scan_reg + CNT_W'(1);
                        end
                    end
                end
                S_LAST_WT:
                begin
                    cur_val_reg <= rd_data;
                    try_dn_reg  <= 1'b1;
                    state_reg   <= S_UP_RD;
                end
                S_UP_RD:
                begin
                    if (pos_reg != '0)
                    begin
                        state_reg <= S_UP_CMP;
                    end
                    else
                    begin
                        state_reg <= try_dn_reg ? S_DN_L : S_FIN;
                    end
                end
                S_UP_CMP:
                begin
                    if (up_less)
                    begin
                        pos_reg    <= parent;
                        try_dn_reg <= 1'b0;
                        state_reg  <= S_UP_RD;
                    end
                    else
                    begin
                        state_reg <= try_dn_reg ? S_DN_L : S_FIN;
                    end
                end
                S_DN_L:
                begin
                    state_reg <= l_in ? S_DN_R : S_FIN;
                end
                S_DN_R:
                begin
                    l_val_reg <= rd_data;
                    r_ok_reg  <= r_in;
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    if (dn_move)
                    begin
                        pos_reg   <= dn_idx;
                        state_reg <= S_DN_L;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    done_reg       <= 1'b1;
                    status_out_reg <= status_reg;
                    min_out_reg    <= (count_reg == '0) ? '0 : root_reg;
                    cnt_out_reg    <= COUNT_OUT_W'(count_reg);
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign status      = status_out_reg;
    assign min_value   = min_out_reg;
    assign entry_count = cnt_out_reg;

    `MHIK_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `MHIK_ASSERT_SAME(a_write_in_range, wr_en, CNT_W'(wr_addr) < count_reg)
    `MHIK_ASSERT_NEXT(a_accept_busy, accept, busy)
    `MHIK_ASSERT_NEXT(a_fin_done, state_reg == S_FIN, done && !busy)
    `MHIK_ASSERT_SAME(a_full_count, done && (status == ST_FULL),
        entry_count == COUNT_OUT_W'(CAPACITY))

endmodule

`default_nettype wire
